### sv/cpfm_pkg.sv
// Package for the capture period and frequency meter.
// Holds fixed field widths, reset values and the divider status type.
// No dependencies.
package cpfm_pkg;

  localparam int CAPTURE_W = 32;
  localparam int PERIOD_W  = 33;
  localparam int FREQ_W    = 32;
  localparam int CLOCK_W   = 32;

  localparam logic [CLOCK_W-1:0] CLOCK_RESET = 32'd42000000;

  // Quotient bits produced by the divider, and the width of its step counter.
  localparam int DIV_STEPS = FREQ_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

### sv/cpfm_in_if.sv
// Capture input channel: valid/ready handshake with one capture value per beat.
// Depends on cpfm_pkg.
interface cpfm_in_if
  import cpfm_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CAPTURE_W-1:0] capture_value;

  modport source (output valid, output capture_value, input ready);
  modport sink   (input valid, input capture_value, output ready);
endinterface

### sv/cpfm_out_if.sv
// Result channel: valid/ready handshake with period and frequency per beat.
// Depends on cpfm_pkg.
interface cpfm_out_if
  import cpfm_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] period_counts;
  logic [FREQ_W-1:0]   frequency_hz;

  modport source (output valid, output period_counts, output frequency_hz, input ready);
  modport sink   (input valid, input period_counts, input frequency_hz, output ready);
endinterface

### sv/capture_period_frequency_meter.sv
// Top level of the capture period and frequency meter.
// Depends on cpfm_pkg, cpfm_in_if, cpfm_out_if and cpfm_divider.
//
//   port       dir   beat contents
//   in_chan    sink  capture_value (32 bits)
//   out_chan   src   period_counts (33 bits), frequency_hz (32 bits)
//   cfg_*      in    counter_clock_hz, written when cfg_we is high
//
// A first capture is stored as the start point and gives no result.
// A second capture starts a one-bit-per-step division; the result is
// written to the output register when the divider reports done.
// Synchronous active-low reset clears the state and sets the clock to 42 MHz.
// Input is held off during division and while a result waits with a second
// capture pending; a first capture is still taken while a result waits.
module capture_period_frequency_meter
  import cpfm_pkg::*;
#(
  parameter int COUNTER_BITS = 32
)(
  input  logic               clk,
  input  logic               rst_n,
  cpfm_in_if.sink            in_chan,
  cpfm_out_if.source         out_chan,
  input  logic               cfg_we,
  input  logic [CLOCK_W-1:0] cfg_wdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                      state_r, state_nxt;
  logic                      awaiting_r, awaiting_nxt;
  logic [COUNTER_BITS-1:0]   first_r, first_nxt;
  logic [CLOCK_W-1:0]        clock_r, clock_nxt;
  logic [PERIOD_W-1:0]       period_r, period_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [PERIOD_W-1:0]       out_period_r, out_period_nxt;
  logic [FREQ_W-1:0]         out_freq_r, out_freq_nxt;

  logic                      accept;
  logic                      div_start;
  logic [COUNTER_BITS-1:0]   cap_low;
  logic [COUNTER_BITS-1:0]   diff;
  logic [COUNTER_BITS:0]     period_raw;
  logic [PERIOD_W-1:0]       period_ext;
  div_sts_t                  div_sts;
  logic [FREQ_W-1:0]         div_quo;

  assign in_chan.ready = (state_r == ST_IDLE) && !(awaiting_r && out_valid_r);
  assign accept        = in_chan.valid && in_chan.ready;
  assign div_start     = accept && awaiting_r;

  assign cap_low    = in_chan.capture_value[COUNTER_BITS-1:0];
  assign diff       = cap_low - first_r;
  assign period_raw = (diff == '0) ? {1'b1, {COUNTER_BITS{1'b0}}} : {1'b0, diff};
  assign period_ext = PERIOD_W'(period_raw);

  cpfm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (clock_r),
    .divisor  (period_ext),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt      = state_r;
    awaiting_nxt   = awaiting_r;
    first_nxt      = first_r;
    clock_nxt      = cfg_we ? cfg_wdata : clock_r;
    period_nxt     = period_r;
    out_valid_nxt  = out_valid_r;
    out_period_nxt = out_period_r;
    out_freq_nxt   = out_freq_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (awaiting_r) begin
            awaiting_nxt = 1'b0;
            period_nxt   = period_ext;
            state_nxt    = ST_DIV;
          end else begin
            awaiting_nxt = 1'b1;
            first_nxt    = cap_low;
          end
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          out_valid_nxt  = 1'b1;
          out_period_nxt = period_r;
          out_freq_nxt   = div_quo;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      awaiting_r  <= 1'b0;
      clock_r     <= CLOCK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      awaiting_r  <= awaiting_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
    end
    first_r      <= first_nxt;
    period_r     <= period_nxt;
    out_period_r <= out_period_nxt;
    out_freq_r   <= out_freq_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.period_counts = out_period_r;
  assign out_chan.frequency_hz  = out_freq_r;

  a_no_input_while_dividing: assert property (
    @(posedge clk) disable iff (!rst_n) (state_r == ST_DIV) |-> !in_chan.ready
  ) else $error("input ready while a division is running");

  a_done_only_when_dividing: assert property (
    @(posedge clk) disable iff (!rst_n) div_sts.done |-> (state_r == ST_DIV)
  ) else $error("divider finished outside a division");

  a_done_into_empty_output: assert property (
    @(posedge clk) disable iff (!rst_n) div_sts.done |-> !out_valid_r
  ) else $error("result would overwrite a pending beat");

  a_second_capture_starts_divide: assert property (
    @(posedge clk) disable iff (!rst_n)
    (accept && awaiting_r) |=> (state_r == ST_DIV && div_sts.busy && period_r != '0)
  ) else $error("second capture did not start a division");

endmodule

### sv/cpfm_divider.sv
// Restoring divider that produces one quotient bit per cycle.
// Divides the counter clock by the period; depends on cpfm_pkg.
module cpfm_divider
  import cpfm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [CLOCK_W-1:0]  dividend,
  input  logic [PERIOD_W-1:0] divisor,
  output div_sts_t            sts,
  output logic [FREQ_W-1:0]   quotient
);

  logic [FREQ_W-1:0]    quo_r, quo_nxt;
  logic [PERIOD_W-1:0]  rem_r, rem_nxt;
  logic [PERIOD_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [PERIOD_W-1:0]  trial;
  logic                 fits;

  // The remainder always stays below the divisor, so its top bit is zero here.
  assign trial = {rem_r[PERIOD_W-2:0], quo_r[FREQ_W-1]};
  assign fits  = (trial >= dvs_r);

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = FREQ_W'(dividend);
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = DIV_CNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? (trial - dvs_r) : trial;
      quo_nxt  = {quo_r[FREQ_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

### sim/tb_top.sv
// Self-checking testbench for capture_period_frequency_meter: capture pairs and counter clock
// settings in, predicted period and frequency results compared beat by beat on the way out.
// Depends on cpfm_pkg, cpfm_in_if, cpfm_out_if and the meter RTL.
module tb_top;
  import cpfm_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 40;
  localparam int STALL_LIMIT  = 3000;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [FREQ_W-1:0]   freq;
  } meas_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CLOCK_W-1:0] cfg_wdata = '0;

  cpfm_in_if  in_chan ();
  cpfm_out_if out_chan ();

  capture_period_frequency_meter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  logic [CAPTURE_W-1:0] capture_queue[$];
  meas_t                expected_meas[$];
  logic [CLOCK_W-1:0]   clock_hz_model = CLOCK_RESET;
  logic                 armed_second = 1'b0;
  logic [CAPTURE_W-1:0] first_cap = '0;
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_idle_pct = 0;
  int unsigned          hold_req = 0;
  int unsigned          hold_seen = 0;
  int unsigned          hold_left = 0;
  int unsigned          stall_count = 0;
  int unsigned          errors = 0;

  initial begin
    in_chan.valid         = 1'b0;
    in_chan.capture_value = '0;
    out_chan.ready        = 1'b0;
  end

  function automatic void take_capture(logic [CAPTURE_W-1:0] cap);
    logic [CAPTURE_W-1:0] span;
    logic [63:0]          quot;
    meas_t                m;
    if (!armed_second) begin
      first_cap    = cap;
      armed_second = 1'b1;
    end else begin
      span     = cap - first_cap;
      m.period = (span == '0) ? {1'b1, {CAPTURE_W{1'b0}}} : {1'b0, span};
      quot     = 64'(clock_hz_model) / 64'(m.period);
      m.freq   = quot[FREQ_W-1:0];
      expected_meas.push_back(m);
      armed_second = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Capture driver.
  always @(posedge clk) begin
    logic                 vld_n;
    logic [CAPTURE_W-1:0] data_n;
    vld_n  = in_chan.valid;
    data_n = in_chan.capture_value;
    if (!rst_n) begin
      vld_n = 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        take_capture(in_chan.capture_value);
        vld_n = 1'b0;
      end
      if (!vld_n && capture_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        vld_n  = 1'b1;
        data_n = capture_queue.pop_front();
      end
    end
    in_chan.valid         <= vld_n;
    in_chan.capture_value <= data_n;
  end

  // Result monitor and receiver.
  always @(posedge clk) begin
    meas_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_meas.size() == 0) begin
          report_mismatch("unexpected result beat", 64'(out_chan.period_counts), 64'd0);
        end else begin
          want = expected_meas.pop_front();
          if (out_chan.period_counts !== want.period) begin
            report_mismatch("period_counts", 64'(out_chan.period_counts), 64'(want.period));
          end
          if (out_chan.frequency_hz !== want.freq) begin
            report_mismatch("frequency_hz", 64'(out_chan.frequency_hz), 64'(want.freq));
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen      <= hold_req;
        hold_left      <= HOLD_CYCLES;
        out_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left      <= hold_left - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count == STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic set_clock(logic [CLOCK_W-1:0] hz);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= hz;
    @(posedge clk);
    cfg_we    <= 1'b0;
    clock_hz_model = hz;
    @(negedge clk);
  endtask

  task automatic add_pair(logic [CAPTURE_W-1:0] first, logic [CAPTURE_W-1:0] second);
    capture_queue.push_back(first);
    capture_queue.push_back(second);
  endtask

  task automatic add_random_pairs(int unsigned count);
    logic [CAPTURE_W-1:0] first;
    logic [CAPTURE_W-1:0] delta;
    for (int unsigned i = 0; i < count; i++) begin
      first = $urandom;
      case ($urandom_range(0, 9))
        0: delta = '0;
        1: delta = $urandom_range(1, 16);
        2: delta = $urandom_range(1, 65535);
        3: delta = '0 - $urandom_range(1, 16);
        4: delta = $urandom_range(1000000, 100000000);
        default: delta = $urandom;
      endcase
      add_pair(first, first + delta);
    end
  endtask

  task automatic drain();
    while (capture_queue.size() != 0 || in_chan.valid || expected_meas.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 26;
    recv_idle_pct = 55;
    add_pair(32'h0000_0000, 32'h0000_0000);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_pair(32'h0000_0000, 32'h0000_0001);
    add_pair(32'hFFFF_FFFF, 32'h0000_0000);
    add_pair(32'h0000_0000, 32'hFFFF_FFFF);
    add_pair(32'h0000_0001, 32'h0000_0000);
    add_pair(32'h8000_0000, 32'h7FFF_FFFF);
    add_pair(32'h1234_5678, 32'h1234_5678 + CLOCK_RESET);
    drain();

    set_clock(32'hFFFF_FFFF);
    add_pair(32'h0000_0000, 32'h0000_0001);
    add_pair(32'h5555_5555, 32'h5555_5555);
    add_random_pairs(100);
    drain();

    set_clock(32'd1);
    add_pair(32'hAAAA_AAAA, 32'hAAAA_AAAB);
    add_pair(32'h0000_0000, 32'h0000_0002);
    add_random_pairs(100);
    drain();

    send_idle_pct = 55;
    recv_idle_pct = 26;
    set_clock(32'd0);
    add_pair(32'h0000_0000, 32'h0000_0001);
    add_random_pairs(100);
    drain();

    set_clock($urandom);
    add_random_pairs(150);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_clock(CLOCK_RESET);
    hold_req++;
    add_random_pairs(150);
    drain();

    set_clock($urandom_range(1, 100000));
    add_random_pairs(150);
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
